FILE: rtl/core/msiva_pkg.sv
`default_nettype none
package msiva_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RELEASE,
    ST_RESP
  } state_t;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam int FIELD_W = 6;

  typedef struct packed {
    logic hit;
    logic last;
  } scan_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/msiva_ram.sv
`default_nettype none
module msiva_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/msiva_run_scan.sv
`default_nettype none
module msiva_run_scan #(
  parameter int NUM_VECTORS = 64,
  parameter int CW = $clog2(NUM_VECTORS + 1),
  parameter int LW = (CW > msiva_pkg::FIELD_W) ? CW : msiva_pkg::FIELD_W
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                restart,
  input  wire logic                bit_valid,
  input  wire logic                bit_used,
  input  wire logic [LW-1:0]       len,
  output msiva_pkg::scan_res_t     res,
  output logic      [CW-1:0]       run_base
);

  logic [LW-1:0] run_r;
  logic [CW-1:0] start_r;
  logic [CW-1:0] idx_r;
  logic [LW-1:0] run_inc;

  assign run_inc  = run_r + LW'(1);
  assign run_base = start_r;

  always_comb begin
    res.hit  = bit_valid && !bit_used && (run_inc == len);
    res.last = bit_valid && (idx_r == CW'(NUM_VECTORS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      run_r   <= '0;
      start_r <= '0;
      idx_r   <= '0;
    end else if (bit_valid) begin
      idx_r <= idx_r + CW'(1);
      if (bit_used) begin
        run_r   <= '0;
        start_r <= idx_r + CW'(1);
      end else begin
        run_r <= run_inc;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/msi_vector_run_allocator_core.sv
// Release: accept, release state, response state; zero-count allocate: accept, response state.
// Allocate: accept, then one vector mark read per cycle from the single-read-port
// map RAM in the scan state, one mark write per vector marked (count) in the mark state,
// and the response state. One item is in work at a time; a result waits in the output register.
// After reset a clearing pass frees every vector; no item is accepted until it ends.
`default_nettype none
module msi_vector_run_allocator_core #(
  parameter int NUM_VECTORS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_func,
  input  wire logic [5:0] in_count,
  input  wire logic [5:0] in_vector,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_status,
  output logic      [5:0] out_base_vector
);

  localparam int AW = $clog2(NUM_VECTORS);
  localparam int CW = $clog2(NUM_VECTORS + 1);
  localparam int LW = (CW > msiva_pkg::FIELD_W) ? CW : msiva_pkg::FIELD_W;

  msiva_pkg::state_t state_r, state_nxt;

  logic          func_r;
  logic [5:0]    count_r;
  logic [5:0]    vec_r;
  logic [CW-1:0] clr_r;
  logic [CW-1:0] issue_r;
  logic          rd_valid_r;
  logic [LW-1:0] mark_i_r;
  logic [CW-1:0] base_full_r;
  logic          res_status_r;
  logic [5:0]    res_base_r;
  logic          out_valid_r;
  logic          out_status_r;
  logic [5:0]    out_base_r;

  logic          accept;
  logic          load_out;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;
  logic [LW-1:0] count_lw;
  logic [CW-1:0] mark_sum;
  logic          vec_in_range;
  logic          mark_last;
  logic          issue_ok;

  msiva_pkg::scan_res_t scan_res;
  logic [CW-1:0]        scan_base;

  assign accept       = in_valid && !in_stall;
  assign count_lw     = LW'(count_r);
  assign mark_sum     = base_full_r + CW'(mark_i_r);
  assign mark_last    = (mark_i_r + LW'(1)) == count_lw;
  assign vec_in_range = LW'(vec_r) < LW'(NUM_VECTORS);
  assign issue_ok     = issue_r < CW'(NUM_VECTORS);

  msiva_ram #(
    .WIDTH (1),
    .DEPTH (NUM_VECTORS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  msiva_run_scan #(
    .NUM_VECTORS (NUM_VECTORS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (accept),
    .bit_valid (rd_valid_r),
    .bit_used  (ram_rdata),
    .len       (count_lw),
    .res       (scan_res),
    .run_base  (scan_base)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msiva_pkg::ST_CLEAR: begin
        if (clr_r == CW'(NUM_VECTORS - 1)) state_nxt = msiva_pkg::ST_IDLE;
      end
      msiva_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_func == msiva_pkg::FUNC_RELEASE) state_nxt = msiva_pkg::ST_RELEASE;
          else if (in_count == '0)                state_nxt = msiva_pkg::ST_RESP;
          else                                    state_nxt = msiva_pkg::ST_SCAN;
        end
      end
      msiva_pkg::ST_SCAN: begin
        if (scan_res.hit)       state_nxt = msiva_pkg::ST_MARK;
        else if (scan_res.last) state_nxt = msiva_pkg::ST_RESP;
      end
      msiva_pkg::ST_MARK: begin
        if (mark_last) state_nxt = msiva_pkg::ST_RESP;
      end
      msiva_pkg::ST_RELEASE: state_nxt = msiva_pkg::ST_RESP;
      msiva_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) state_nxt = msiva_pkg::ST_IDLE;
      end
      default: state_nxt = msiva_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_r[AW-1:0];
    ram_wdata = 1'b0;
    case (state_r)
      msiva_pkg::ST_CLEAR: ram_we = 1'b1;
      msiva_pkg::ST_IDLE:  in_stall = 1'b0;
      msiva_pkg::ST_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = mark_sum[AW-1:0];
        ram_wdata = 1'b1;
      end
      msiva_pkg::ST_RELEASE: begin
        ram_we    = vec_in_range;
        ram_waddr = AW'(vec_r);
      end
      msiva_pkg::ST_RESP: load_out = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msiva_pkg::ST_CLEAR;
      clr_r       <= '0;
      issue_r     <= '0;
      rd_valid_r  <= 1'b0;
      mark_i_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == msiva_pkg::ST_CLEAR) clr_r <= clr_r + CW'(1);
      if (accept) begin
        issue_r    <= '0;
        rd_valid_r <= 1'b0;
        mark_i_r   <= '0;
      end else if (state_r == msiva_pkg::ST_SCAN) begin
        rd_valid_r <= issue_ok && !scan_res.hit && !scan_res.last;
        if (issue_ok) issue_r <= issue_r + CW'(1);
      end else begin
        rd_valid_r <= 1'b0;
      end
      if (state_r == msiva_pkg::ST_MARK) mark_i_r <= mark_i_r + LW'(1);
      if (load_out)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r       <= in_func;
      count_r      <= in_count;
      vec_r        <= in_vector;
      res_status_r <= msiva_pkg::STATUS_OK;
      res_base_r   <= '0;
    end
    if (state_r == msiva_pkg::ST_SCAN) begin
      if (scan_res.hit) begin
        base_full_r  <= scan_base;
        res_status_r <= msiva_pkg::STATUS_OK;
        res_base_r   <= 6'(scan_base);
      end else if (scan_res.last) begin
        res_status_r <= msiva_pkg::STATUS_FAIL;
        res_base_r   <= '0;
      end
    end
    if (state_r == msiva_pkg::ST_RELEASE) begin
      res_status_r <= msiva_pkg::STATUS_OK;
      res_base_r   <= vec_r;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_base_r   <= res_base_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_base_vector = out_base_r;

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msiva_pkg::ST_SCAN) |-> !ram_we)
    else $error("map written during scan");

  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msiva_pkg::ST_MARK) |-> (mark_sum < CW'(NUM_VECTORS)))
    else $error("mark address beyond last vector");

  a_mark_is_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msiva_pkg::ST_MARK) |-> (func_r == msiva_pkg::FUNC_ALLOC))
    else $error("marking on a release item");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == msiva_pkg::ST_RESP))
    else $error("result loaded outside response state");

  a_fail_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == msiva_pkg::STATUS_FAIL) |-> (out_base_r == '0))
    else $error("failed allocate with nonzero base");

endmodule
`default_nettype wire
